/* sv/pmjg_pkg.sv */
// ----------------------------------------------------------------------------
// Pointer motion jitter gate package
// Item kinds, configuration register indexes and reset values that the gate
// core uses.
// ----------------------------------------------------------------------------
package pmjg_pkg;

    // Item kind carried in the slave tuser field.
    typedef logic [1:0] t_kind;

    localparam t_kind KIND_X     = 2'd0;
    localparam t_kind KIND_Y     = 2'd1;
    localparam t_kind KIND_OTHER = 2'd2;
    localparam t_kind KIND_KEY   = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index REG_THRESHOLD      = 3'd0;
    localparam t_cfg_index REG_IDLE_TIMEOUT   = 3'd1;
    localparam t_cfg_index REG_KEY_IGNORE     = 3'd2;
    localparam t_cfg_index REG_CLEAR_ON_KEY   = 3'd3;
    localparam t_cfg_index REG_CLEAR_KEY_IDLE = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] RESET_THRESHOLD    = 16'd50;
    localparam logic [15:0] RESET_IDLE_TIMEOUT = 16'd1000;
    localparam logic [15:0] RESET_KEY_IGNORE   = 16'd0;

    // Saturation limits of the per-axis accumulators.
    localparam logic [31:0] SUM_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SUM_MIN = 32'h8000_0000;

endpackage

/* sv/pointer_motion_jitter_gate_core.sv */
// Path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the master side takes results; the accumulator,
// moving-flag and timestamp update is combinational between the input and result registers.
// Stalls: while a finished result waits on the master side, the input register refills only if empty.
// Reset (i_rst_n low, synchronous): both stages empty, state cleared, registers at defaults.
// ----------------------------------------------------------------------------
// Pointer motion jitter gate core
// Decides per item whether a relative pointer event passes on or is dropped,
// with a key-press blanking window, an idle clear and an L1 distance deadzone.
// ----------------------------------------------------------------------------
module pointer_motion_jitter_gate_core
    import pmjg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Slave stream side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [31:0] now_ms, [47:32] motion_delta
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] req_type

    // Master stream side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] pass_event, [7:1] zero

    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_index  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers
    logic [15:0] r_distance_threshold;
    logic [15:0] r_idle_timeout_ms;
    logic [15:0] r_key_ignore_ms;
    logic        r_clear_on_key;
    logic        r_clear_on_key_if_idle;

    // Input register
    logic               r_in_valid;
    t_kind              r_in_kind;
    logic [31:0]        r_in_now;
    logic signed [15:0] r_in_delta;

    // Gate state
    logic signed [31:0] r_sum_x;
    logic signed [31:0] r_sum_y;
    logic               r_moving;
    logic [31:0]        r_last_motion_time;
    logic [31:0]        r_last_key_time;

    // Result register
    logic r_out_valid;
    logic r_out_pass;

    // Next values
    logic signed [31:0] n_sum_x;
    logic signed [31:0] n_sum_y;
    logic               n_moving;
    logic [31:0]        n_last_motion_time;
    logic [31:0]        n_last_key_time;
    logic               n_pass;

    logic advance;
    logic step;

    // Handshakes: the input stage moves on whenever the result register is empty or its result is taken.
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_pass};

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance_threshold   <= RESET_THRESHOLD;
            r_idle_timeout_ms      <= RESET_IDLE_TIMEOUT;
            r_key_ignore_ms        <= RESET_KEY_IGNORE;
            r_clear_on_key         <= 1'b0;
            r_clear_on_key_if_idle <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_THRESHOLD:      r_distance_threshold   <= i_cfg_data;
                REG_IDLE_TIMEOUT:   r_idle_timeout_ms      <= i_cfg_data;
                REG_KEY_IGNORE:     r_key_ignore_ms        <= i_cfg_data;
                REG_CLEAR_ON_KEY:   r_clear_on_key         <= i_cfg_data[0];
                REG_CLEAR_KEY_IDLE: r_clear_on_key_if_idle <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_kind  <= i_s_axis_tuser;
            r_in_now   <= i_s_axis_tdata[31:0];
            r_in_delta <= i_s_axis_tdata[47:32];
        end
    end

    // Gate decision and state update for the item in the input register.
    always_comb begin
        logic [31:0]        key_gap;
        logic [31:0]        motion_gap;
        logic               in_window;
        logic               idle;
        logic signed [31:0] base_x;
        logic signed [31:0] base_y;
        logic signed [31:0] acc;
        logic signed [32:0] acc_sum;
        logic signed [31:0] acc_sat;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic [31:0]        mag_x;
        logic [31:0]        mag_y;
        logic [32:0]        l1;
        logic               reached;

        key_gap    = r_in_now - r_last_key_time;
        motion_gap = r_in_now - r_last_motion_time;
        in_window  = (r_key_ignore_ms != 16'd0) && (key_gap <= {16'd0, r_key_ignore_ms});
        idle       = motion_gap > {16'd0, r_idle_timeout_ms};

        base_x = idle ? 32'sd0 : r_sum_x;
        base_y = idle ? 32'sd0 : r_sum_y;

        // Saturating add of the delta to the selected axis.
        acc     = (r_in_kind == KIND_X) ? base_x : base_y;
        acc_sum = {acc[31], acc} + {{17{r_in_delta[15]}}, r_in_delta};
        if (acc_sum[32] != acc_sum[31]) begin
            acc_sat = acc_sum[32] ? SUM_MIN : SUM_MAX;
        end else begin
            acc_sat = acc_sum[31:0];
        end
        new_x = (r_in_kind == KIND_X) ? acc_sat : base_x;
        new_y = (r_in_kind == KIND_X) ? base_y : acc_sat;

        // L1 distance, wide enough for two full magnitudes.
        mag_x   = new_x[31] ? (32'd0 - new_x) : new_x;
        mag_y   = new_y[31] ? (32'd0 - new_y) : new_y;
        l1      = {1'b0, mag_x} + {1'b0, mag_y};
        reached = l1 >= {17'd0, r_distance_threshold};

        n_sum_x            = r_sum_x;
        n_sum_y            = r_sum_y;
        n_moving           = r_moving;
        n_last_motion_time = r_last_motion_time;
        n_last_key_time    = r_last_key_time;
        n_pass             = 1'b1;

        case (r_in_kind)
            KIND_OTHER: begin
                n_pass = 1'b1;
            end
            KIND_KEY: begin
                n_last_key_time = r_in_now;
                if (r_clear_on_key) begin
                    n_sum_x  = 32'sd0;
                    n_sum_y  = 32'sd0;
                    n_moving = 1'b0;
                end else if (r_clear_on_key_if_idle && !r_moving) begin
                    n_sum_x = 32'sd0;
                    n_sum_y = 32'sd0;
                end
            end
            default: begin
                // Motion along X or Y.
                if (in_window) begin
                    n_pass = 1'b0;
                end else begin
                    n_last_motion_time = r_in_now;
                    if (r_moving && !idle) begin
                        n_pass = 1'b1;
                    end else begin
                        n_sum_x  = new_x;
                        n_sum_y  = new_y;
                        n_moving = reached;
                        n_pass   = reached;
                    end
                end
            end
        endcase
    end

    // Gate state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x            <= 32'sd0;
            r_sum_y            <= 32'sd0;
            r_moving           <= 1'b0;
            r_last_motion_time <= 32'd0;
            r_last_key_time    <= 32'd0;
        end else if (step) begin
            r_sum_x            <= n_sum_x;
            r_sum_y            <= n_sum_y;
            r_moving           <= n_moving;
            r_last_motion_time <= n_last_motion_time;
            r_last_key_time    <= n_last_key_time;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_pass <= n_pass;
        end
    end

    // Non-motion items always pass.
    a_other_key_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && (r_in_kind == KIND_OTHER || r_in_kind == KIND_KEY)) |=> r_out_pass)
        else $error("other or key item was dropped");

    // The moving flag only rises on a motion item that is passed on.
    a_moving_rise_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_moving) |-> (r_out_valid && r_out_pass))
        else $error("moving flag rose without a passed item");

    // Gate state only changes when an item moves into the result register.
    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> ($stable(r_sum_x) && $stable(r_sum_y) && $stable(r_moving)
                   && $stable(r_last_motion_time) && $stable(r_last_key_time)))
        else $error("gate state changed without an item");

    // With both stages full and the master stalled, no new item is taken.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while pipeline is full");

endmodule
